// ===== rtl/core/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg: shared types and constants for the depth-first path search
// Node and field widths, config register indexes, the controller state
// enum and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dfs_pkg;

  // Fixed field widths
  localparam int unsigned NODE_W     = 4;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;

  // Default graph size; at most 16 nodes can exist (node fields are 4 bits)
  localparam int unsigned NODES_DEF  = 16;
  localparam int unsigned SLOTS      = 16;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL  = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_POP,
    ST_SCAN,
    ST_WALK,
    ST_EMIT,
    ST_SINGLE
  } dfs_state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic row_wr;     // store incoming row
    logic init;       // clear search state, push start node
    logic pop;        // pop frontier top, load its candidate children
    logic scan_step;  // generate lowest candidate child
    logic walk_init;  // goal generated: seed path buffer with goal
    logic walk_step;  // follow one parent link
    logic emit_step;  // load next path node into output register
    logic single;     // load the one-result answer into output register
  } dfs_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic bad_node;   // start or goal outside the graph
    logic same_node;  // start equals goal
    logic stack_empty;
    logic cand_empty;
    logic cand_goal;  // lowest candidate is the goal
    logic walk_done;
    logic emit_last;
    logic out_free;   // output register can take a new result
  } dfs_sts_t;

endpackage

// ===== rtl/core/dfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfs_ctrl: search sequencer
// Loads rows, then steps the datapath through pop, child scan, parent
// walk and path emission.
// ----------------------------------------------------------------------------
module dfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_row_i,
  output logic              in_stall_o,
  input  dfs_pkg::dfs_sts_t sts_i,
  output dfs_pkg::dfs_cmd_t cmd_o
);
  import dfs_pkg::*;

  dfs_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && last_row_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.bad_node || sts_i.same_node) state_d = ST_SINGLE;
        else                                   state_d = ST_POP;
      end
      ST_POP: begin
        if (sts_i.stack_empty) state_d = ST_SINGLE;
        else                   state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.cand_empty)     state_d = ST_POP;
        else if (sts_i.cand_goal) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.walk_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) state_d = ST_IDLE;
      end
      ST_SINGLE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.row_wr  = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.init = !(sts_i.bad_node || sts_i.same_node);
      end
      ST_POP: begin
        cmd_o.pop = !sts_i.stack_empty;
      end
      ST_SCAN: begin
        cmd_o.scan_step = !sts_i.cand_empty;
        cmd_o.walk_init = !sts_i.cand_empty && sts_i.cand_goal;
      end
      ST_WALK: begin
        cmd_o.walk_step = !sts_i.walk_done;
      end
      ST_EMIT: begin
        cmd_o.emit_step = sts_i.out_free;
      end
      ST_SINGLE: begin
        cmd_o.single = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/dfs_dp.sv =====
// ----------------------------------------------------------------------------
// dfs_dp: search datapath
// Adjacency rows, LIFO frontier, explored/in-frontier masks, parent
// links, path buffer, config registers and the result register.
// ----------------------------------------------------------------------------
module dfs_dp #(
  parameter int unsigned NODES = dfs_pkg::NODES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config
  input  logic                             cfg_we_i,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // row payload
  input  logic [dfs_pkg::NODE_W-1:0]       row_index_i,
  input  logic [dfs_pkg::ROW_W-1:0]        row_bits_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dfs_pkg::NODE_W-1:0]       path_node_o,
  output logic                             found_o,
  output logic                             last_node_o,
  // controller link
  input  dfs_pkg::dfs_cmd_t                cmd_i,
  output dfs_pkg::dfs_sts_t                sts_o
);
  import dfs_pkg::*;

  // Nodes that exist, index and counter widths
  localparam int unsigned LIVE = (NODES < SLOTS) ? NODES : SLOTS;
  localparam int unsigned IW   = $clog2(LIVE);
  localparam int unsigned CW   = $clog2(LIVE + 1);
  localparam logic [NODE_W:0] LIVE_V = (NODE_W + 1)'(LIVE);
  localparam logic [LIVE-1:0] ONE_L  = LIVE'(1);

  typedef logic [IW-1:0]   idx_t;
  typedef logic [LIVE-1:0] mask_t;

  // Lowest set bit of a mask
  function automatic idx_t low_bit(input mask_t m);
    idx_t r;
    r = '0;
    for (int i = LIVE - 1; i >= 0; i--) begin
      if (m[i]) r = IW'(i);
    end
    return r;
  endfunction

  // Storage
  mask_t adj_q    [LIVE];
  idx_t  stack_q  [LIVE];
  idx_t  parent_q [LIVE];
  idx_t  path_q   [LIVE];

  logic [NODE_W-1:0] start_q, goal_q;
  logic [CW-1:0]     cnt_q, len_q;
  mask_t             expl_q, inf_q, cand_q;
  idx_t              node_q, wnode_q;
  logic              out_valid_q;
  logic [NODE_W-1:0] out_node_q;
  logic              out_found_q, out_last_q;

  // Pop path
  logic [CW-1:0] cnt_m1;
  idx_t          top_node;
  mask_t         pop_bit, expl_pop, inf_pop, pop_cand;
  // Scan path
  idx_t          j_idx;
  mask_t         j_bit;
  logic          hit_goal;
  // Walk and emit
  logic [CW-1:0] len_m1;
  idx_t          par_node;
  logic          start_ok, goal_ok, single_ok, out_free;

  assign cnt_m1   = cnt_q - CW'(1);
  assign top_node = stack_q[cnt_m1[IW-1:0]];
  assign pop_bit  = ONE_L << top_node;
  assign expl_pop = expl_q | pop_bit;
  assign inf_pop  = inf_q & ~pop_bit;
  assign pop_cand = adj_q[top_node] & ~(expl_pop | inf_pop);

  assign j_idx    = low_bit(cand_q);
  assign j_bit    = ONE_L << j_idx;
  assign hit_goal = (NODE_W'(j_idx) == goal_q);

  assign len_m1   = len_q - CW'(1);
  assign par_node = parent_q[wnode_q];

  assign start_ok  = ({1'b0, start_q} < LIVE_V);
  assign goal_ok   = ({1'b0, goal_q} < LIVE_V);
  assign single_ok = start_ok && goal_ok && (start_q == goal_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Status to controller
  always_comb begin
    sts_o             = '0;
    sts_o.bad_node    = !(start_ok && goal_ok);
    sts_o.same_node   = (start_q == goal_q);
    sts_o.stack_empty = (cnt_q == '0);
    sts_o.cand_empty  = (cand_q == '0);
    sts_o.cand_goal   = hit_goal;
    sts_o.walk_done   = (NODE_W'(wnode_q) == start_q) || (len_q == CW'(LIVE));
    sts_o.emit_last   = (len_q == CW'(1));
    sts_o.out_free    = out_free;
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      goal_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START: start_q <= cfg_data_i;
        REG_GOAL:  goal_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Array storage (no reset: read only after being written)
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_wr && ({1'b0, row_index_i} < LIVE_V)) begin
      adj_q[row_index_i[IW-1:0]] <= row_bits_i[LIVE-1:0];
    end
    if (cmd_i.init) begin
      stack_q[0]                    <= start_q[IW-1:0];
      parent_q[start_q[IW-1:0]]     <= start_q[IW-1:0];
    end
    if (cmd_i.scan_step) begin
      parent_q[j_idx] <= node_q;
      if (!hit_goal) stack_q[cnt_q[IW-1:0]] <= j_idx;
    end
    if (cmd_i.walk_init) begin
      path_q[0] <= j_idx;
    end
    if (cmd_i.walk_step) begin
      path_q[len_q[IW-1:0]] <= par_node;
    end
  end

  // Search control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      expl_q  <= '0;
      inf_q   <= '0;
      cand_q  <= '0;
      len_q   <= '0;
      node_q  <= '0;
      wnode_q <= '0;
    end else begin
      if (cmd_i.init) begin
        cnt_q  <= CW'(1);
        expl_q <= '0;
        inf_q  <= ONE_L << start_q[IW-1:0];
        cand_q <= '0;
      end
      if (cmd_i.pop) begin
        cnt_q  <= cnt_m1;
        expl_q <= expl_pop;
        inf_q  <= inf_pop;
        cand_q <= pop_cand;
        node_q <= top_node;
      end
      if (cmd_i.scan_step) begin
        cand_q <= cand_q & ~j_bit;
        if (!hit_goal) begin
          cnt_q <= cnt_q + CW'(1);
          inf_q <= inf_q | j_bit;
        end
      end
      if (cmd_i.walk_init) begin
        len_q   <= CW'(1);
        wnode_q <= j_idx;
      end
      if (cmd_i.walk_step) begin
        len_q   <= len_q + CW'(1);
        wnode_q <= par_node;
      end
      if (cmd_i.emit_step) begin
        len_q <= len_m1;
      end
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_step || cmd_i.single) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      out_node_q  <= NODE_W'(path_q[len_m1[IW-1:0]]);
      out_found_q <= 1'b1;
      out_last_q  <= (len_q == CW'(1));
    end else if (cmd_i.single) begin
      out_node_q  <= single_ok ? start_q : '0;
      out_found_q <= single_ok;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_node_o = out_node_q;
  assign found_o     = out_found_q;
  assign last_node_o = out_last_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(LIVE))
    else $error("frontier count above node count");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CW'(LIVE))
    else $error("path length above node count");

  a_mask_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (expl_q & inf_q) == '0)
    else $error("node both explored and in frontier");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_step || cmd_i.single) |-> out_free)
    else $error("result loaded over an untaken result");

endmodule

// ===== rtl/core/dfs_path_search_top.sv =====
// ----------------------------------------------------------------------------
// dfs_path_search_top: depth-first path search over an adjacency matrix
// Stores matrix rows, searches from start to goal, streams the path.
// ----------------------------------------------------------------------------
// Usage:
//   Write start_node (index 0) and goal_node (index 1) on the cfg port while
//   the block is idle. Send one matrix row per input transfer; rows load at
//   one per cycle. The transfer with last_row set also starts the search,
//   and in_stall_o stays high until the final result has been loaded into
//   the output register.
//   Search steps: the endpoints are checked, then each popped node has its
//   candidate children generated one by one, lowest index first, until none
//   is left or the goal is generated; a pop that finds the frontier empty
//   ends the search. Once the goal is generated, a parent walk collects the
//   path nodes, and then one result is emitted per path node.
//   Results: the path from start to goal, one node per transfer, found=1,
//   last_node on the goal. An unreachable goal, or a start/goal outside the
//   graph, gives one result with path_node=0, found=0. Start equal to goal
//   gives one result carrying the start node with found=1.
//   A stalled receiver holds the output register; emission waits for it.
//   Reset clears the config registers, the search state and the output
//   valid; matrix rows must be rewritten before a search.
// ----------------------------------------------------------------------------
module dfs_path_search_top #(
  parameter int unsigned NODES = dfs_pkg::NODES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dfs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // row channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [dfs_pkg::NODE_W-1:0]       row_index_i,
  input  logic [dfs_pkg::ROW_W-1:0]        row_bits_i,
  input  logic                             last_row_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [dfs_pkg::NODE_W-1:0]       path_node_o,
  output logic                             found_o,
  output logic                             last_node_o
);
  import dfs_pkg::*;

  dfs_cmd_t cmd;
  dfs_sts_t sts;

  // Sequencer
  dfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_row_i (last_row_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  dfs_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .row_index_i (row_index_i),
    .row_bits_i  (row_bits_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .path_node_o (path_node_o),
    .found_o     (found_o),
    .last_node_o (last_node_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
